[rtl/hdrtd_pkg.sv]
package hdrtd_pkg;

    localparam int CFG_W = 14;
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0] RESET_SOURCE_WIDTH  = 14'd256;
    localparam logic [CFG_W-1:0] RESET_SOURCE_HEIGHT = 14'd128;

    localparam int CH_W  = 16;
    localparam int TM_W  = 8;
    localparam int COL_W = 8;
    localparam int ROW_W = 13;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam int TM_STAGES = 8;

    typedef enum logic [2:0] {
        FS_START,
        FS_DIV_H,
        FS_DIV_R,
        FS_RUN
    } hdrtd_fstate_t;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             done;
    } hdrtd_item_t;

    typedef struct packed {
        logic        valid;
        hdrtd_item_t item;
    } hdrtd_xfer_t;

    typedef struct packed {
        hdrtd_item_t     item;
        logic [TM_W-1:0] red_tm;
        logic [TM_W-1:0] green_tm;
        logic [TM_W-1:0] blue_tm;
    } hdrtd_stage_t;

    typedef logic [255:0] hdrtd_big_t;
    typedef logic [16:0] hdrtd_thr_entry_t;
    typedef hdrtd_thr_entry_t [255:0] hdrtd_thr_t;

    function automatic hdrtd_big_t big_pow(input hdrtd_big_t b, input int n);
        hdrtd_big_t r;
        r = hdrtd_big_t'(1);
        for (int i = 0; i < n; i++) begin
            r = r * b;
        end
        return r;
    endfunction

    // exact test: (c/(c+256))^5 * 510^11 >= (2k-1)^11
    function automatic logic tm_reaches(input int c, input int k);
        hdrtd_big_t lhs;
        hdrtd_big_t rhs;
        lhs = big_pow(hdrtd_big_t'(510), 11) * big_pow(hdrtd_big_t'(c), 5);
        rhs = big_pow(hdrtd_big_t'(2 * k - 1), 11) * big_pow(hdrtd_big_t'(c + 256), 5);
        return lhs >= rhs;
    endfunction

    // smallest input code that maps to at least k
    function automatic hdrtd_thr_t tm_build();
        hdrtd_thr_t t;
        int lo;
        int hi;
        int mid;
        t = '0;
        for (int k = 1; k < 256; k++) begin
            lo = 0;
            hi = 65536;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (tm_reaches(mid, k)) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            t[k] = 17'(lo);
        end
        return t;
    endfunction

    localparam hdrtd_thr_t TM_THR = tm_build();

    function automatic logic [TM_W-1:0] tm_bit(input logic [CH_W-1:0] c,
                                               input logic [TM_W-1:0] acc,
                                               input logic [2:0] b);
        logic [TM_W-1:0] cand;
        cand = acc | (8'd1 << b);
        return ({1'b0, c} >= TM_THR[cand]) ? cand : acc;
    endfunction

    function automatic hdrtd_stage_t stage_step(input hdrtd_stage_t s, input logic [2:0] b);
        hdrtd_stage_t r;
        r = s;
        r.red_tm   = tm_bit(s.item.red, s.red_tm, b);
        r.green_tm = tm_bit(s.item.green, s.green_tm, b);
        r.blue_tm  = tm_bit(s.item.blue, s.blue_tm, b);
        return r;
    endfunction

endpackage

[rtl/hdr_tonemap_decimator_top.sv]
// HDR tonemap and nearest-neighbor downscaler.
// Input: source pixels in raster order, three u8.8 channels, on s_valid/s_ready.
// Output: OUT_WIDTH x max(1, OUT_WIDTH*H/W) frame of tonemapped gamma bytes with
// output column, row and a frame_done flag on the last pixel, on m_valid/m_ready.
// Source pixels that are not selected produce no transfer.
// Throughput: one source pixel per cycle outside setup; the front stalls only
// during setup or when the four-entry queue to the tonemap pipeline is full.
// A selected pixel is written into the queue, then passes the 8-stage threshold
// search, one output bit per stage, whose first stage loads straight from the
// queue head, and shows on m_valid from the last stage.
// Reset and every write to source_width or source_height restart the frame and
// run two serial divisions (output height, H/output height) on a bit-serial
// divider; s_ready stays low until both divisions are done.
// A stalled receiver holds the output pipeline; the queue then fills and
// s_ready drops until results drain.
module hdr_tonemap_decimator_top #(
    parameter int OUT_WIDTH = 256,
    parameter int MAX_SIDE  = 8192
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hdrtd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hdrtd_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hdrtd_pkg::CH_W-1:0]    s_red_in,
    input  logic [hdrtd_pkg::CH_W-1:0]    s_green_in,
    input  logic [hdrtd_pkg::CH_W-1:0]    s_blue_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hdrtd_pkg::TM_W-1:0]    m_red_out,
    output logic [hdrtd_pkg::TM_W-1:0]    m_green_out,
    output logic [hdrtd_pkg::TM_W-1:0]    m_blue_out,
    output logic [hdrtd_pkg::COL_W-1:0]   m_out_col,
    output logic [hdrtd_pkg::ROW_W-1:0]   m_out_row,
    output logic                          m_frame_done
);

    hdrtd_pkg::hdrtd_xfer_t push, head;
    logic                   q_full, pop;

    hdrtd_front #(.OUT_WIDTH(OUT_WIDTH), .MAX_SIDE(MAX_SIDE)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_red_in   (s_red_in),
        .s_green_in (s_green_in),
        .s_blue_in  (s_blue_in),
        .q_full     (q_full),
        .push       (push)
    );

    hdrtd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .full    (q_full)
    );

    hdrtd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_out_col    (m_out_col),
        .m_out_row    (m_out_row),
        .m_frame_done (m_frame_done)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push.valid && q_full))
        else $error("push into full queue");

    a_done_last_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_out_col == hdrtd_pkg::COL_W'(OUT_WIDTH - 1))
        else $error("frame_done away from last column");

    a_push_needs_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> s_valid && !q_full)
        else $error("queue push without input transfer");

endmodule

[rtl/hdrtd_divider.sv]
module hdrtd_divider #(
    parameter int DW = 24,
    parameter int VW = 14
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] div_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[VW-1:0] : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/hdrtd_front.sv]
module hdrtd_front #(
    parameter int OUT_WIDTH = 256,
    parameter int MAX_SIDE  = 8192
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [hdrtd_pkg::IDX_W-1:0]  cfg_index,
    input  logic [hdrtd_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [hdrtd_pkg::CH_W-1:0]   s_red_in,
    input  logic [hdrtd_pkg::CH_W-1:0]   s_green_in,
    input  logic [hdrtd_pkg::CH_W-1:0]   s_blue_in,
    input  logic                         q_full,
    output hdrtd_pkg::hdrtd_xfer_t       push
);

    localparam int SIDE  = (MAX_SIDE > OUT_WIDTH) ? MAX_SIDE : OUT_WIDTH;
    localparam int SW    = $clog2(SIDE + 1);
    localparam int OCW   = $clog2(OUT_WIDTH + 1);
    localparam int CRW   = $clog2(OUT_WIDTH);
    localparam int DW    = $clog2(OUT_WIDTH * SIDE + 1);
    localparam int RK    = SW + CRW;
    localparam int RECIP = ((1 << RK) + OUT_WIDTH - 1) / OUT_WIDTH;
    localparam int MW    = 2 * SW + 2;

    hdrtd_pkg::hdrtd_fstate_t state_reg, state_next;

    logic [hdrtd_pkg::CFG_W-1:0] src_width_reg, src_height_reg;
    logic [SW-1:0]  eff_w, eff_h;
    logic [SW-1:0]  src_col_reg, src_row_reg;
    logic [OCW-1:0] out_col_reg;
    logic [SW-1:0]  col_q_reg;
    logic [CRW-1:0] col_r_reg;
    logic [SW-1:0]  out_row_reg;
    logic [SW-1:0]  row_q_reg, row_r_reg;
    logic [SW-1:0]  oh_reg;
    logic [SW-1:0]  qw_reg, qh_reg, rh_reg;
    logic [CRW-1:0] rw_reg;

    logic          div_start, div_done;
    logic [DW-1:0] div_dividend, div_quotient;
    logic [SW-1:0] div_divisor, div_remainder;
    logic [SW-1:0] oh_calc;

    logic [MW-1:0]  w_prod;
    logic [SW-1:0]  qw_calc, qw_mul;
    logic [CRW-1:0] rw_calc;

    logic           accept, row_hit, col_hit, hit, row_end, frame_end;
    logic [CRW:0]   col_r_sum;
    logic           col_wrap;
    logic [SW:0]    row_r_sum;
    logic           row_wrap;

    int unsigned tw, th;

    always_comb begin
        tw = 32'(src_width_reg);
        if (tw < OUT_WIDTH) tw = OUT_WIDTH;
        if (tw > MAX_SIDE) tw = MAX_SIDE;
        th = 32'(src_height_reg);
        if (th < 1) th = 1;
        if (th > MAX_SIDE) th = MAX_SIDE;
        eff_w = SW'(tw);
        eff_h = SW'(th);
    end

    // W / OUT_WIDTH by reciprocal multiply, exact for any W below 2**SW
    assign w_prod  = MW'(eff_w) * MW'(RECIP);
    assign qw_calc = SW'(w_prod >> RK);
    assign qw_mul  = qw_reg * SW'(OUT_WIDTH);
    assign rw_calc = CRW'(eff_w - qw_mul);

    hdrtd_divider #(.DW(DW), .VW(SW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign oh_calc = (div_quotient == '0) ? SW'(1) : SW'(div_quotient);

    // setup sequence: OUT_WIDTH*H / W, then H / out_height
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hdrtd_pkg::FS_START: state_next = hdrtd_pkg::FS_DIV_H;
            hdrtd_pkg::FS_DIV_H: if (div_done) state_next = hdrtd_pkg::FS_DIV_R;
            hdrtd_pkg::FS_DIV_R: if (div_done) state_next = hdrtd_pkg::FS_RUN;
            hdrtd_pkg::FS_RUN:   state_next = hdrtd_pkg::FS_RUN;
            default:             state_next = hdrtd_pkg::FS_START;
        endcase
        // writes to unknown indexes leave the frame running
        if (cfg_we && (cfg_index inside {hdrtd_pkg::REG_SOURCE_WIDTH,
                                         hdrtd_pkg::REG_SOURCE_HEIGHT})) begin
            state_next = hdrtd_pkg::FS_START;
        end
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = DW'(OUT_WIDTH) * DW'(eff_h);
        div_divisor  = eff_w;
        case (state_reg)
            hdrtd_pkg::FS_START: begin
                div_start = 1'b1;
            end
            hdrtd_pkg::FS_DIV_H: begin
                div_start    = div_done;
                div_dividend = DW'(eff_h);
                div_divisor  = oh_calc;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hdrtd_pkg::FS_START;
            src_width_reg  <= hdrtd_pkg::RESET_SOURCE_WIDTH;
            src_height_reg <= hdrtd_pkg::RESET_SOURCE_HEIGHT;
        end else begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == hdrtd_pkg::REG_SOURCE_WIDTH) begin
                src_width_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == hdrtd_pkg::REG_SOURCE_HEIGHT) begin
                src_height_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            hdrtd_pkg::FS_START: qw_reg <= qw_calc;
            hdrtd_pkg::FS_DIV_H: begin
                rw_reg <= rw_calc;
                if (div_done) oh_reg <= oh_calc;
            end
            hdrtd_pkg::FS_DIV_R: begin
                if (div_done) begin
                    qh_reg <= SW'(div_quotient);
                    rh_reg <= div_remainder;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready = (state_reg == hdrtd_pkg::FS_RUN) && !q_full;
    assign accept  = s_valid && s_ready;

    assign row_hit = (out_row_reg < oh_reg) && (src_row_reg == row_q_reg);
    assign col_hit = (out_col_reg < OCW'(OUT_WIDTH)) && (src_col_reg == col_q_reg);
    assign hit     = row_hit && col_hit;

    assign row_end   = ({1'b0, src_col_reg} + 1'b1) >= {1'b0, eff_w};
    assign frame_end = ({1'b0, src_row_reg} + 1'b1) >= {1'b0, eff_h};

    assign col_r_sum = {1'b0, col_r_reg} + {1'b0, rw_reg};
    assign col_wrap  = col_r_sum >= (CRW+1)'(OUT_WIDTH);
    assign row_r_sum = {1'b0, row_r_reg} + {1'b0, rh_reg};
    assign row_wrap  = row_r_sum >= {1'b0, oh_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn || state_reg != hdrtd_pkg::FS_RUN) begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            col_q_reg   <= '0;
            col_r_reg   <= '0;
            out_row_reg <= '0;
            row_q_reg   <= '0;
            row_r_reg   <= '0;
        end else if (accept) begin
            src_col_reg <= src_col_reg + 1'b1;
            if (hit) begin
                out_col_reg <= out_col_reg + 1'b1;
                col_q_reg   <= col_q_reg + qw_reg + SW'(col_wrap);
                col_r_reg   <= col_wrap ? CRW'(col_r_sum - (CRW+1)'(OUT_WIDTH))
                                        : CRW'(col_r_sum);
            end
            if (row_end) begin
                src_col_reg <= '0;
                out_col_reg <= '0;
                col_q_reg   <= '0;
                col_r_reg   <= '0;
                src_row_reg <= src_row_reg + 1'b1;
                if (row_hit) begin
                    out_row_reg <= out_row_reg + 1'b1;
                    row_q_reg   <= row_q_reg + qh_reg + SW'(row_wrap);
                    row_r_reg   <= row_wrap ? SW'(row_r_sum - {1'b0, oh_reg})
                                            : SW'(row_r_sum);
                end
                if (frame_end) begin
                    src_row_reg <= '0;
                    out_row_reg <= '0;
                    row_q_reg   <= '0;
                    row_r_reg   <= '0;
                end
            end
        end
    end

    always_comb begin
        push.valid      = accept && hit;
        push.item.red   = s_red_in;
        push.item.green = s_green_in;
        push.item.blue  = s_blue_in;
        push.item.col   = hdrtd_pkg::COL_W'(out_col_reg);
        push.item.row   = hdrtd_pkg::ROW_W'(out_row_reg);
        push.item.done  = (out_col_reg == OCW'(OUT_WIDTH - 1))
                       && (out_row_reg == oh_reg - 1'b1);
    end

endmodule

[rtl/hdrtd_queue.sv]
module hdrtd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hdrtd_pkg::hdrtd_xfer_t push,
    input  logic                   pop,
    output hdrtd_pkg::hdrtd_xfer_t head,
    output logic                   full
);

    hdrtd_pkg::hdrtd_item_t mem [hdrtd_pkg::Q_DEPTH];

    logic [hdrtd_pkg::Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [hdrtd_pkg::Q_AW:0]   count_reg;
    logic                       do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (hdrtd_pkg::Q_AW+1)'(push.valid)
                                   - (hdrtd_pkg::Q_AW+1)'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) mem[wr_ptr_reg] <= push.item;
    end

    assign head.valid = count_reg != '0;
    assign head.item  = mem[rd_ptr_reg];
    assign full       = count_reg == (hdrtd_pkg::Q_AW+1)'(hdrtd_pkg::Q_DEPTH);

endmodule

[rtl/hdrtd_back.sv]
module hdrtd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hdrtd_pkg::hdrtd_xfer_t        head,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hdrtd_pkg::TM_W-1:0]    m_red_out,
    output logic [hdrtd_pkg::TM_W-1:0]    m_green_out,
    output logic [hdrtd_pkg::TM_W-1:0]    m_blue_out,
    output logic [hdrtd_pkg::COL_W-1:0]   m_out_col,
    output logic [hdrtd_pkg::ROW_W-1:0]   m_out_row,
    output logic                          m_frame_done
);

    localparam int NS = hdrtd_pkg::TM_STAGES;

    hdrtd_pkg::hdrtd_stage_t pipe_reg [NS];
    logic [NS-1:0]           pipe_v_reg;
    hdrtd_pkg::hdrtd_stage_t s_in;
    logic                    en;

    // whole pipe advances unless the last stage holds an untaken result
    assign en  = !pipe_v_reg[NS-1] || m_ready;
    assign pop = en && head.valid;

    always_comb begin
        s_in.item     = head.item;
        s_in.red_tm   = '0;
        s_in.green_tm = '0;
        s_in.blue_tm  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_v_reg <= '0;
        end else if (en) begin
            pipe_v_reg <= {pipe_v_reg[NS-2:0], head.valid};
        end
    end

    // stage i settles result bit NS-1-i by threshold compare
    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= hdrtd_pkg::stage_step(s_in, 3'(NS - 1));
            for (int i = 1; i < NS; i++) begin
                pipe_reg[i] <= hdrtd_pkg::stage_step(pipe_reg[i-1], 3'(NS - 1 - i));
            end
        end
    end

    assign m_valid      = pipe_v_reg[NS-1];
    assign m_red_out    = pipe_reg[NS-1].red_tm;
    assign m_green_out  = pipe_reg[NS-1].green_tm;
    assign m_blue_out   = pipe_reg[NS-1].blue_tm;
    assign m_out_col    = pipe_reg[NS-1].item.col;
    assign m_out_row    = pipe_reg[NS-1].item.row;
    assign m_frame_done = pipe_reg[NS-1].item.done;

endmodule
